/* src/trce_pkg.sv */
// package for the transport receiver connection engine
// operation, segment, connection state, status and fsm codes, default sizes
package trce_pkg;

   localparam int CONNECTIONS_DEF  = 16;
   localparam int BUFFER_BYTES_DEF = 4096;
   localparam logic [15:0] CLOSEWAIT_RESET = 16'd100;

   typedef enum logic [2:0] {
      OP_OPEN   = 3'd0,
      OP_ACCEPT = 3'd1,
      OP_CLOSE  = 3'd2,
      OP_READ   = 3'd3,
      OP_SEG    = 3'd4,
      OP_TICK   = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      SEG_SYN     = 3'd0,
      SEG_SYNACK  = 3'd1,
      SEG_FIN     = 3'd2,
      SEG_FINACK  = 3'd3,
      SEG_DATA    = 3'd4,
      SEG_DATAACK = 3'd5
   } seg_kind_type;

   typedef enum logic [1:0] {
      CS_CLOSED = 2'd0,
      CS_LISTEN = 2'd1,
      CS_CONN   = 2'd2,
      CS_CWAIT  = 2'd3
   } conn_state_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_FAIL    = 2'd1,
      STAT_NOTRDY  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE = 2'd0,
      FSM_EVAL = 2'd1,
      FSM_FIN  = 2'd2
   } fsm_type;

endpackage

/* src/trce_ram.sv */
// generic single-write, single-read synchronous ram with registered read
// no dependencies
module trce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end
   assign rdata = rdata_ff;
endmodule

/* src/transport_receiver_connection_engine_top.sv */
// transport receiver connection engine: connection table in one ram,
// read-modify-write sequencer. depends on trce_pkg and trce_ram
//
//  channel | ports                          | handshake
//  --------+--------------------------------+--------------------------------
//  request | start, busy, req_*             | taken when start and not busy
//  result  | rsp_strobe, rsp_*              | one cycle pulse, no stall
//  config  | csr_we, csr_wdata              | written when csr_we is high
//
// accept, close and read pass through ram read, update and result register.
// open, segment and tick sweep the table one entry per cycle through the ram
// read port; segment stops at the first matching entry, open then writes.
// reset clears the per-entry valid bits; an entry never written
// reads as all zero. results cannot be stalled.
module transport_receiver_connection_engine_top #(
   parameter int CONNECTIONS  = trce_pkg::CONNECTIONS_DEF,
   parameter int BUFFER_BYTES = trce_pkg::BUFFER_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_operation,
   input  logic [15:0] req_local_port,
   input  logic [3:0]  req_socket_id,
   input  logic [12:0] req_read_length,
   input  logic [2:0]  req_seg_type,
   input  logic [15:0] req_seg_src_port,
   input  logic [15:0] req_seg_dest_port,
   input  logic [31:0] req_seg_seq_num,
   input  logic [12:0] req_seg_length,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_socket_out,
   output logic        rsp_ack_valid,
   output logic [2:0]  rsp_ack_type,
   output logic [15:0] rsp_ack_src_port,
   output logic [15:0] rsp_ack_dest_port,
   output logic [31:0] rsp_ack_num,
   output logic        rsp_store_valid,
   output logic [11:0] rsp_buffer_offset,
   output logic [3:0]  rsp_buffer_socket,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);
   import trce_pkg::*;

   localparam int AW = $clog2(CONNECTIONS > 1 ? CONNECTIONS : 2);
   localparam int HW = $clog2(BUFFER_BYTES);
   localparam int FW = HW + 1;
   localparam int SW = (FW > 13 ? FW : 13) + 1;
   localparam logic [SW-1:0] BB = SW'(BUFFER_BYTES);
   localparam logic [AW-1:0] LAST = AW'(CONNECTIONS - 1);

   typedef struct packed {
      logic           used;
      logic [15:0]    sport;
      logic [15:0]    cport;
      conn_state_type cstate;
      logic [31:0]    exp;
      logic [HW-1:0]  head;
      logic [FW-1:0]  fill;
      logic [15:0]    cw;
   } rec_type;

   typedef struct packed {
      status_type    status;
      logic [3:0]    sock;
      logic          ack_valid;
      seg_kind_type  ack_type;
      logic [15:0]   ack_src;
      logic [15:0]   ack_dest;
      logic [31:0]   ack_num;
      logic          store;
      logic [11:0]   offset;
      logic [3:0]    bsock;
   } rsp_type;

   fsm_type state_ff, state_in;
   logic [15:0] cwt_ff;
   op_type      op_ff;
   logic [15:0] port_ff, src_ff, dst_ff;
   logic [AW-1:0] idx_ff, idx_in;
   logic [12:0] rlen_ff, slen_ff;
   seg_kind_type stype_ff;
   logic [31:0] seq_ff;
   logic        hit_ff, hit_in, free_ok_ff, free_ok_in;
   logic [AW-1:0] free_ff, free_in;
   logic [CONNECTIONS-1:0] vld_ff;
   logic        rvld_ff;
   logic        fire_ff;
   rsp_type     rsp_ff, rsp;
   logic        fire, done;

   logic           we;
   logic [AW-1:0]  waddr, raddr;
   rec_type        wrec, rec, rdata;

   logic start_ok, sid_ok;
   logic [SW-1:0] fill_x, len_x, sum_x;
   logic [FW:0]   ring;

   trce_ram #(.WIDTH($bits(rec_type)), .DEPTH(CONNECTIONS)) u_tab (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wrec),
      .raddr(raddr), .rdata(rdata)
   );

   assign rec  = rvld_ff ? rdata : '0;
   assign busy = (state_ff != FSM_IDLE);
   assign start_ok = start && !busy;
   assign sid_ok = 32'(req_socket_id) < CONNECTIONS;

   // read address: requested socket or entry zero on a transaction, next entry while sweeping
   always_comb begin
      raddr = idx_ff + AW'(1);
      idx_in = idx_ff + AW'(1);
      if (state_ff == FSM_IDLE) begin
         raddr = (req_operation == OP_ACCEPT || req_operation == OP_CLOSE ||
                  req_operation == OP_READ) ? AW'(req_socket_id) : '0;
         idx_in = raddr;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (start_ok) begin
               unique case (req_operation)
                  OP_OPEN, OP_SEG, OP_TICK:      state_in = FSM_EVAL;
                  OP_ACCEPT, OP_CLOSE, OP_READ: if (sid_ok) state_in = FSM_EVAL;
                  default:                       state_in = FSM_IDLE;
               endcase
            end
         end
         FSM_EVAL: if (done) state_in = (op_ff == OP_OPEN) ? FSM_FIN : FSM_IDLE;
         FSM_FIN:  state_in = FSM_IDLE;
         default:  state_in = FSM_IDLE;
      endcase
   end

   // datapath and result
   always_comb begin
      we = 1'b0;
      waddr = idx_ff;
      wrec = rec;
      fire = 1'b0;
      done = 1'b0;
      rsp = '0;
      rsp.status = STAT_FAIL;
      hit_in = hit_ff;
      free_ok_in = free_ok_ff;
      free_in = free_ff;
      fill_x = SW'(rec.fill);
      len_x = (op_ff == OP_READ) ? SW'(rlen_ff) : SW'(slen_ff);
      sum_x = fill_x + len_x;
      ring = (FW+1)'(rec.head) + (FW+1)'(rec.fill);
      if (ring >= (FW+1)'(BUFFER_BYTES)) ring = ring - (FW+1)'(BUFFER_BYTES);
      unique case (state_ff)
         FSM_IDLE: begin
            hit_in = 1'b0;
            free_ok_in = 1'b0;
            free_in = '0;
            if (start_ok && state_in == FSM_IDLE) fire = 1'b1;
         end
         FSM_EVAL: begin
            case (op_ff)
               OP_ACCEPT: begin
                  done = 1'b1;
                  fire = 1'b1;
                  if (rec.used) begin
                     unique case (rec.cstate)
                        CS_CLOSED: begin
                           we = 1'b1;
                           wrec.cstate = CS_LISTEN;
                           rsp.status = STAT_NOTRDY;
                        end
                        CS_LISTEN: rsp.status = STAT_NOTRDY;
                        CS_CONN:   rsp.status = STAT_OK;
                        default:   rsp.status = STAT_FAIL;
                     endcase
                  end
               end
               OP_CLOSE: begin
                  done = 1'b1;
                  fire = 1'b1;
                  if (rec.used && rec.cstate == CS_CLOSED) begin
                     we = 1'b1;
                     wrec = '0;
                     rsp.status = STAT_OK;
                  end
               end
               OP_READ: begin
                  done = 1'b1;
                  fire = 1'b1;
                  if (rec.used && rec.cstate == CS_CONN) begin
                     if (fill_x < len_x) begin
                        rsp.status = STAT_NOTRDY;
                     end else begin
                        ring = (FW+1)'(rec.head) + (FW+1)'(rlen_ff);
                        if (ring >= (FW+1)'(BUFFER_BYTES))
                           ring = ring - (FW+1)'(BUFFER_BYTES);
                        we = 1'b1;
                        wrec.head = HW'(ring);
                        wrec.fill = FW'(fill_x - len_x);
                        rsp.status = STAT_OK;
                        rsp.offset = 12'(rec.head);
                        rsp.bsock = 4'(idx_ff);
                     end
                  end
               end
               OP_OPEN: begin
                  if (rec.used && rec.sport == port_ff) hit_in = 1'b1;
                  if (!rec.used && !free_ok_ff) begin
                     free_ok_in = 1'b1;
                     free_in = idx_ff;
                  end
                  done = (idx_ff == LAST);
               end
               OP_SEG: begin
                  if (rec.used && rec.sport == dst_ff) begin
                     done = 1'b1;
                     fire = 1'b1;
                     unique case (rec.cstate)
                        CS_LISTEN: if (stype_ff == SEG_SYN) begin
                           we = 1'b1;
                           wrec.cport = src_ff;
                           wrec.cstate = CS_CONN;
                           wrec.exp = seq_ff;
                           rsp.status = STAT_OK;
                           rsp.ack_valid = 1'b1;
                           rsp.ack_type = SEG_SYNACK;
                        end
                        CS_CONN: if (rec.cport == src_ff) begin
                           case (stype_ff)
                              SEG_SYN: begin
                                 we = 1'b1;
                                 wrec.exp = seq_ff;
                                 rsp.status = STAT_OK;
                                 rsp.ack_valid = 1'b1;
                                 rsp.ack_type = SEG_SYNACK;
                              end
                              SEG_DATA: begin
                                 if (seq_ff == rec.exp && sum_x <= BB) begin
                                    we = 1'b1;
                                    wrec.fill = FW'(sum_x);
                                    wrec.exp = seq_ff + 32'(slen_ff);
                                    rsp.store = 1'b1;
                                    rsp.offset = 12'(ring);
                                    rsp.bsock = 4'(idx_ff);
                                 end
                                 rsp.status = STAT_OK;
                                 rsp.ack_valid = 1'b1;
                                 rsp.ack_type = SEG_DATAACK;
                                 rsp.ack_num = wrec.exp;
                              end
                              SEG_FIN: begin
                                 we = 1'b1;
                                 wrec.cstate = CS_CWAIT;
                                 wrec.cw = cwt_ff;
                                 rsp.status = STAT_OK;
                                 rsp.ack_valid = 1'b1;
                                 rsp.ack_type = SEG_FINACK;
                              end
                              default: rsp.status = STAT_FAIL;
                           endcase
                        end
                        CS_CWAIT: if (rec.cport == src_ff && stype_ff == SEG_FIN) begin
                           rsp.status = STAT_OK;
                           rsp.ack_valid = 1'b1;
                           rsp.ack_type = SEG_FINACK;
                        end
                        default: rsp.status = STAT_FAIL;
                     endcase
                     if (rsp.ack_valid) begin
                        rsp.ack_src = wrec.sport;
                        rsp.ack_dest = wrec.cport;
                     end
                  end else if (idx_ff == LAST) begin
                     done = 1'b1;
                     fire = 1'b1;
                  end
               end
               OP_TICK: begin
                  if (rec.used && rec.cstate == CS_CWAIT) begin
                     we = 1'b1;
                     if (rec.cw != '0) wrec.cw = rec.cw - 16'd1;
                     if (wrec.cw == '0) wrec.cstate = CS_CLOSED;
                  end
                  if (idx_ff == LAST) begin
                     done = 1'b1;
                     fire = 1'b1;
                     rsp.status = STAT_OK;
                  end
               end
               default: begin
                  done = 1'b1;
                  fire = 1'b1;
               end
            endcase
         end
         FSM_FIN: begin
            fire = 1'b1;
            if (!hit_ff && free_ok_ff) begin
               we = 1'b1;
               waddr = free_ff;
               wrec = '0;
               wrec.used = 1'b1;
               wrec.sport = port_ff;
               rsp.status = STAT_OK;
               rsp.sock = 4'(free_ff);
            end
         end
         default: fire = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
         cwt_ff <= CLOSEWAIT_RESET;
         vld_ff <= '0;
         fire_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) cwt_ff <= csr_wdata;
         if (we) vld_ff[waddr] <= 1'b1;
         fire_ff <= fire;
      end
   end

   always_ff @(posedge clock) begin
      rvld_ff <= vld_ff[raddr];
      idx_ff <= idx_in;
      hit_ff <= hit_in;
      free_ok_ff <= free_ok_in;
      free_ff <= free_in;
      if (fire) rsp_ff <= rsp;
      if (start_ok) begin
         op_ff <= op_type'(req_operation);
         port_ff <= req_local_port;
         rlen_ff <= req_read_length;
         stype_ff <= seg_kind_type'(req_seg_type);
         src_ff <= req_seg_src_port;
         dst_ff <= req_seg_dest_port;
         seq_ff <= req_seg_seq_num;
         slen_ff <= req_seg_length;
      end
   end

   assign rsp_strobe        = fire_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_socket_out    = rsp_ff.sock;
   assign rsp_ack_valid     = rsp_ff.ack_valid;
   assign rsp_ack_type      = rsp_ff.ack_type;
   assign rsp_ack_src_port  = rsp_ff.ack_src;
   assign rsp_ack_dest_port = rsp_ff.ack_dest;
   assign rsp_ack_num       = rsp_ff.ack_num;
   assign rsp_store_valid   = rsp_ff.store;
   assign rsp_buffer_offset = rsp_ff.offset;
   assign rsp_buffer_socket = rsp_ff.bsock;
endmodule

/* dv/tb.sv */
// testbench for transport_receiver_connection_engine_top: directed table then random
// transactions, checked against set answers or a connection predictor. depends on trce_pkg
module tb;
   import trce_pkg::*;

   localparam int NCONN     = CONNECTIONS_DEF;
   localparam int BUF_BYTES = BUFFER_BYTES_DEF;
   localparam int SETTLE    = NCONN + 8;
   localparam int CYCLE_CAP = 600000;

   typedef struct packed {
      op_type       op;
      logic [15:0]  port;
      logic [3:0]   sid;
      logic [12:0]  rlen;
      seg_kind_type stype;
      logic [15:0]  src;
      logic [15:0]  dst;
      logic [31:0]  seq;
      logic [12:0]  slen;
   } txn_t;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  sock;
      logic        ack_v;
      logic [2:0]  ack_type;
      logic [15:0] ack_src;
      logic [15:0] ack_dst;
      logic [31:0] ack_num;
      logic        store_v;
      logic [11:0] offset;
      logic [3:0]  bsock;
   } answer_t;

   logic        clock, reset, start, busy;
   logic [2:0]  req_operation, req_seg_type;
   logic [15:0] req_local_port, req_seg_src_port, req_seg_dest_port;
   logic [3:0]  req_socket_id;
   logic [12:0] req_read_length, req_seg_length;
   logic [31:0] req_seg_seq_num;
   logic        rsp_strobe, rsp_ack_valid, rsp_store_valid;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_socket_out, rsp_buffer_socket;
   logic [2:0]  rsp_ack_type;
   logic [15:0] rsp_ack_src_port, rsp_ack_dest_port;
   logic [31:0] rsp_ack_num;
   logic [11:0] rsp_buffer_offset;
   logic        csr_we;
   logic [15:0] csr_wdata;

   logic        drv_typed;
   answer_t     drv_answer;

   transport_receiver_connection_engine_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_local_port(req_local_port),
      .req_socket_id(req_socket_id), .req_read_length(req_read_length),
      .req_seg_type(req_seg_type), .req_seg_src_port(req_seg_src_port),
      .req_seg_dest_port(req_seg_dest_port), .req_seg_seq_num(req_seg_seq_num),
      .req_seg_length(req_seg_length), .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status), .rsp_socket_out(rsp_socket_out),
      .rsp_ack_valid(rsp_ack_valid), .rsp_ack_type(rsp_ack_type),
      .rsp_ack_src_port(rsp_ack_src_port), .rsp_ack_dest_port(rsp_ack_dest_port),
      .rsp_ack_num(rsp_ack_num), .rsp_store_valid(rsp_store_valid),
      .rsp_buffer_offset(rsp_buffer_offset), .rsp_buffer_socket(rsp_buffer_socket),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   // predicted connection table
   bit             used   [NCONN];
   bit [15:0]      sport  [NCONN];
   bit [15:0]      cport  [NCONN];
   conn_state_type cstate [NCONN];
   bit [31:0]      eseq   [NCONN];
   bit [11:0]      head   [NCONN];
   bit [12:0]      fill   [NCONN];
   bit [15:0]      cwcount[NCONN];
   bit [15:0]      cw_ticks;

   answer_t pending_answers[$];
   txn_t    dir_txn[$];
   bit      dir_typed[$];
   answer_t dir_answer[$];
   int      mismatches;
   int      cycles;

   logic [15:0] server_pool[6] = '{16'h0000, 16'hFFFF, 16'h0050, 16'h5A5A, 16'hA5A5, 16'h1234};
   logic [15:0] client_pool[4] = '{16'hFFFF, 16'h0000, 16'h3C3C, 16'hC3C3};

   function automatic void wipe_entry(int i);
      used[i] = 0; sport[i] = 0; cport[i] = 0; cstate[i] = CS_CLOSED;
      eseq[i] = 0; head[i] = 0; fill[i] = 0; cwcount[i] = 0;
   endfunction

   function automatic answer_t make_ack(int i, seg_kind_type k);
      answer_t a;
      a = '0;
      a.ack_v    = 1;
      a.ack_type = k;
      a.ack_src  = sport[i];
      a.ack_dst  = cport[i];
      a.ack_num  = (k == SEG_DATAACK) ? eseq[i] : 32'd0;
      return a;
   endfunction

   // segment handling, go-back-n: only the exact expected sequence is stored
   function automatic answer_t apply_segment(txn_t t);
      answer_t     a;
      int          hit;
      bit          same;
      bit [13:0]   room;
      bit [11:0]   wr_off;
      a   = '0;
      a.status = STAT_FAIL;
      hit = -1;
      for (int i = 0; i < NCONN; i++)
         if (hit < 0 && used[i] && sport[i] == t.dst) hit = i;
      if (hit < 0) return a;
      same = (cport[hit] == t.src);
      case (cstate[hit])
         CS_LISTEN: begin
            if (t.stype != SEG_SYN) return a;
            cport[hit]  = t.src;
            cstate[hit] = CS_CONN;
            eseq[hit]   = t.seq;
            a = make_ack(hit, SEG_SYNACK);
         end
         CS_CONN: begin
            if (!same) return a;
            if (t.stype == SEG_SYN) begin
               eseq[hit] = t.seq;
               a = make_ack(hit, SEG_SYNACK);
            end else if (t.stype == SEG_DATA) begin
               room   = fill[hit] + t.slen;
               wr_off = head[hit] + fill[hit][11:0];
               if (t.seq == eseq[hit] && room <= BUF_BYTES) begin
                  fill[hit] = room[12:0];
                  eseq[hit] = t.seq + t.slen;
                  a = make_ack(hit, SEG_DATAACK);
                  a.store_v = 1;
                  a.offset  = wr_off;
                  a.bsock   = 4'(hit);
               end else begin
                  a = make_ack(hit, SEG_DATAACK);
               end
            end else if (t.stype == SEG_FIN) begin
               cstate[hit]  = CS_CWAIT;
               cwcount[hit] = cw_ticks;
               a = make_ack(hit, SEG_FINACK);
            end else begin
               return a;
            end
         end
         CS_CWAIT: begin
            if (!(same && t.stype == SEG_FIN)) return a;
            a = make_ack(hit, SEG_FINACK);
         end
         default: return a;
      endcase
      a.status = STAT_OK;
      return a;
   endfunction

   function automatic answer_t apply_txn(txn_t t);
      answer_t a;
      int      hit, sid;
      bit      ok_sock;
      a   = '0;
      a.status = STAT_FAIL;
      sid = t.sid;
      ok_sock = used[sid];
      case (t.op)
         OP_OPEN: begin
            hit = -1;
            for (int i = 0; i < NCONN; i++)
               if (used[i] && sport[i] == t.port) hit = i;
            if (hit < 0) begin
               for (int i = NCONN - 1; i >= 0; i--)
                  if (!used[i]) hit = i;
               if (hit >= 0) begin
                  wipe_entry(hit);
                  used[hit]  = 1;
                  sport[hit] = t.port;
                  a.sock     = 4'(hit);
                  a.status   = STAT_OK;
               end
            end
         end
         OP_ACCEPT: if (ok_sock) begin
            case (cstate[sid])
               CS_CLOSED: begin cstate[sid] = CS_LISTEN; a.status = STAT_NOTRDY; end
               CS_LISTEN: a.status = STAT_NOTRDY;
               CS_CONN:   a.status = STAT_OK;
               default:   a.status = STAT_FAIL;
            endcase
         end
         OP_CLOSE: if (ok_sock && cstate[sid] == CS_CLOSED) begin
            wipe_entry(sid);
            a.status = STAT_OK;
         end
         OP_READ: if (ok_sock && cstate[sid] == CS_CONN) begin
            if (fill[sid] < t.rlen) begin
               a.status = STAT_NOTRDY;
            end else begin
               a.offset  = head[sid];
               a.bsock   = 4'(sid);
               head[sid] = head[sid] + t.rlen[11:0];
               fill[sid] = fill[sid] - t.rlen;
               a.status  = STAT_OK;
            end
         end
         OP_SEG: a = apply_segment(t);
         OP_TICK: begin
            for (int i = 0; i < NCONN; i++)
               if (used[i] && cstate[i] == CS_CWAIT) begin
                  if (cwcount[i] > 0) cwcount[i]--;
                  if (cwcount[i] == 0) cstate[i] = CS_CLOSED;
               end
            a.status = STAT_OK;
         end
         default: ;
      endcase
      return a;
   endfunction

   function automatic txn_t random_txn();
      txn_t t;
      int   r, j, cnt;
      t = '0;
      r = $urandom_range(0, 99);
      // pick a used entry to aim at, if any
      j = -1; cnt = 0;
      for (int i = 0; i < NCONN; i++)
         if (used[i]) begin
            cnt++;
            if ($urandom_range(1, cnt) == 1) j = i;
         end
      t.port  = $urandom_range(0, 99) < 60 ? server_pool[$urandom_range(0, 5)]
                                           : 16'($urandom());
      t.sid   = ($urandom_range(0, 3) != 0 && j >= 0) ? j[3:0] : 4'($urandom());
      t.src   = 16'($urandom());
      t.dst   = 16'($urandom());
      t.seq   = $urandom();
      t.stype = SEG_DATA;
      if (r < 8) begin
         t.op = OP_OPEN;
      end else if (r < 18) begin
         t.op = OP_ACCEPT;
      end else if (r < 26) begin
         t.op = OP_CLOSE;
      end else if (r < 43) begin
         t.op = OP_READ;
         t.rlen = 13'($urandom_range(0, 1) ? $urandom_range(0, fill[t.sid])
                                           : $urandom_range(0, BUF_BYTES));
      end else if (r < 88) begin
         t.op = OP_SEG;
         r = $urandom_range(0, 99);
         if (r < 70 && j >= 0) t.dst = sport[j];
         else if (r < 85) t.dst = server_pool[$urandom_range(0, 5)];
         if (j >= 0 && t.dst == sport[j] && $urandom_range(0, 99) < 80) t.src = cport[j];
         else if ($urandom_range(0, 1)) t.src = client_pool[$urandom_range(0, 3)];
         if (j >= 0 && t.dst == sport[j] && $urandom_range(0, 99) < 75) t.seq = eseq[j];
         r = $urandom_range(0, 99);
         if (r < 60)      t.stype = SEG_DATA;
         else if (r < 75) t.stype = SEG_SYN;
         else if (r < 85) t.stype = SEG_FIN;
         else if (r < 90) t.stype = SEG_SYNACK;
         else if (r < 95) t.stype = SEG_FINACK;
         else             t.stype = SEG_DATAACK;
         r = $urandom_range(0, 99);
         t.slen = 13'(r < 60 ? $urandom_range(0, 512) :
                       r < 90 ? $urandom_range(0, BUF_BYTES) : BUF_BYTES);
      end else begin
         t.op = OP_TICK;
      end
      return t;
   endfunction

   task automatic send_txn(txn_t t, bit typed, answer_t ans);
      req_operation     <= t.op;
      req_local_port    <= t.port;
      req_socket_id     <= t.sid;
      req_read_length   <= t.rlen;
      req_seg_type      <= t.stype;
      req_seg_src_port  <= t.src;
      req_seg_dest_port <= t.dst;
      req_seg_seq_num   <= t.seq;
      req_seg_length    <= t.slen;
      drv_typed         <= typed;
      drv_answer        <= ans;
      start             <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_closewait(logic [15:0] v);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      cw_ticks  = v;
   endtask

   task automatic maybe_idle(int pct);
      if ($urandom_range(0, 99) < pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic add_row(op_type op, logic [15:0] port, logic [3:0] sid, logic [12:0] rlen,
                          seg_kind_type k, logic [15:0] src, logic [15:0] dst,
                          logic [31:0] seq, logic [12:0] slen, bit typed,
                          status_type st, logic [3:0] sock);
      txn_t    t;
      answer_t a;
      t = '{op, port, sid, rlen, k, src, dst, seq, slen};
      a = '0;
      a.status = st;
      a.sock   = sock;
      dir_txn.push_back(t);
      dir_typed.push_back(typed);
      dir_answer.push_back(a);
   endtask

   // checker and prediction at each clock edge
   always @(posedge clock) begin
      answer_t got, want;
      txn_t    t;
      if (!reset) begin
         if (rsp_strobe) begin
            got = '{rsp_status, rsp_socket_out, rsp_ack_valid, rsp_ack_type,
                    rsp_ack_src_port, rsp_ack_dest_port, rsp_ack_num,
                    rsp_store_valid, rsp_buffer_offset, rsp_buffer_socket};
            if (pending_answers.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
               want = pending_answers.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
               end
            end
         end
         if (start && !busy) begin
            t = '{op_type'(req_operation), req_local_port, req_socket_id, req_read_length,
                  seg_kind_type'(req_seg_type), req_seg_src_port, req_seg_dest_port,
                  req_seg_seq_num, req_seg_length};
            want = apply_txn(t);
            pending_answers.push_back(drv_typed ? drv_answer : want);
         end
      end
   end

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      logic [15:0] phase_ticks[5] = '{16'd3, 16'd1, 16'hFFFF, 16'd7, 16'd2};
      int          phase_idle[5]  = '{0, 49, 10, 49, 0};
      mismatches = 0;
      cycles     = 0;
      reset = 1; start = 0; csr_we = 0; csr_wdata = 0;
      req_operation = 0; req_local_port = 0; req_socket_id = 0; req_read_length = 0;
      req_seg_type = 0; req_seg_src_port = 0; req_seg_dest_port = 0;
      req_seg_seq_num = 0; req_seg_length = 0; drv_typed = 0; drv_answer = '0;
      for (int i = 0; i < NCONN; i++) wipe_entry(i);
      cw_ticks = CLOSEWAIT_RESET;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      add_row(OP_OPEN,   16'h0000, 0, 0, SEG_SYN, 0, 0, 0, 0, 1, STAT_OK, 0);
      add_row(OP_OPEN,   16'h0000, 0, 0, SEG_SYN, 0, 0, 0, 0, 1, STAT_FAIL, 0);
      add_row(OP_OPEN,   16'hFFFF, 0, 0, SEG_SYN, 0, 0, 0, 0, 1, STAT_OK, 1);
      add_row(OP_READ,   0, 0, 0, SEG_SYN, 0, 0, 0, 0, 1, STAT_FAIL, 0);
      add_row(OP_ACCEPT, 0, 5, 0, SEG_SYN, 0, 0, 0, 0, 1, STAT_FAIL, 0);
      add_row(OP_ACCEPT, 0, 0, 0, SEG_SYN, 0, 0, 0, 0, 1, STAT_NOTRDY, 0);
      add_row(OP_SEG, 0, 0, 0, SEG_DATA, 16'hFFFF, 0, 0, 0, 1, STAT_FAIL, 0);
      add_row(OP_SEG, 0, 0, 0, SEG_SYN, 16'hFFFF, 0, 32'hFFFFFFFF, 0, 0, STAT_OK, 0);
      add_row(OP_ACCEPT, 0, 0, 0, SEG_SYN, 0, 0, 0, 0, 1, STAT_OK, 0);
      add_row(OP_SEG, 0, 0, 0, SEG_DATA, 16'hFFFF, 0, 32'hFFFFFFFF, 13'd4096, 0, STAT_OK, 0);
      add_row(OP_SEG, 0, 0, 0, SEG_DATA, 16'hFFFF, 0, 32'h00000FFF, 13'd1, 0, STAT_OK, 0);
      add_row(OP_READ, 0, 0, 13'd4096, SEG_SYN, 0, 0, 0, 0, 0, STAT_OK, 0);
      add_row(OP_SEG, 0, 0, 0, SEG_DATA, 16'hFFFF, 0, 0, 13'd100, 0, STAT_OK, 0);
      add_row(OP_SEG, 0, 0, 0, SEG_SYN, 16'h1234, 0, 0, 0, 1, STAT_FAIL, 0);
      add_row(OP_SEG, 0, 0, 0, SEG_FINACK, 16'hFFFF, 0, 0, 0, 1, STAT_FAIL, 0);
      add_row(OP_SEG, 0, 0, 0, SEG_DATAACK, 16'hFFFF, 0, 0, 0, 1, STAT_FAIL, 0);
      add_row(OP_SEG, 0, 0, 0, SEG_SYNACK, 16'hFFFF, 0, 0, 0, 1, STAT_FAIL, 0);
      add_row(OP_SEG, 0, 0, 0, SEG_SYN, 16'hFFFF, 0, 32'd5, 0, 0, STAT_OK, 0);
      add_row(OP_READ, 0, 0, 13'd4096, SEG_SYN, 0, 0, 0, 0, 1, STAT_NOTRDY, 0);
      add_row(OP_SEG, 0, 0, 0, SEG_FIN, 16'hFFFF, 0, 0, 0, 0, STAT_OK, 0);
      add_row(OP_SEG, 0, 0, 0, SEG_FIN, 16'hFFFF, 0, 0, 0, 0, STAT_OK, 0);
      add_row(OP_CLOSE, 0, 0, 0, SEG_SYN, 0, 0, 0, 0, 1, STAT_FAIL, 0);
      add_row(OP_TICK, 0, 0, 0, SEG_SYN, 0, 0, 0, 0, 1, STAT_OK, 0);
      add_row(OP_SEG, 0, 0, 0, SEG_SYN, 16'h0001, 16'h1234, 0, 0, 1, STAT_FAIL, 0);
      add_row(OP_CLOSE, 0, 1, 0, SEG_SYN, 0, 0, 0, 0, 1, STAT_OK, 0);
      add_row(OP_CLOSE, 0, 15, 0, SEG_SYN, 0, 0, 0, 0, 1, STAT_FAIL, 0);
      foreach (dir_txn[i]) send_txn(dir_txn[i], dir_typed[i], dir_answer[i]);

      for (int p = 0; p < 5; p++) begin
         write_closewait(phase_ticks[p]);
         for (int n = 0; n < 370; n++) begin
            if (p == 3 && n == 185) drain();
            send_txn(random_txn(), 0, '0);
            maybe_idle(phase_idle[p]);
         end
      end

      drain();
      if (mismatches == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
